### design/assert_macros.svh
// Assertion macros used by the top level of the OTP macro access sequencer.
// Each macro expects a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition seen at one edge brings a consequence at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/otp_mas_pkg.sv
// Package of the OTP macro access sequencer: widths, codes, phase type and result word.
// Used by otp_mas_ctrl, otp_mas_obuf and otp_macro_access_sequencer; depends on nothing.
`timescale 1ns / 1ps
package otp_mas_pkg;

  localparam int unsigned ADDR_BITS = 12;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned CFG_NUM   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned WAIT_W    = 7;
  localparam int unsigned STB_W     = 7;

  // Strobe pin positions.
  localparam int unsigned STB_SEL  = 0;
  localparam int unsigned STB_CLK  = 1;
  localparam int unsigned STB_DIN  = 2;
  localparam int unsigned STB_STBY = 3;
  localparam int unsigned STB_PRG  = 4;
  localparam int unsigned STB_TRM  = 5;
  localparam int unsigned STB_WE   = 6;

  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_PROG = 2'd2;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_PROG = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCESS_SETUP   = 3'd0,
    CFG_TRIM_SETUP     = 3'd1,
    CFG_SELECT_SETUP   = 3'd2,
    CFG_PROG_SEL_SETUP = 3'd3,
    CFG_PROG_SETUP     = 3'd4,
    CFG_PROG_PULSE     = 3'd5,
    CFG_PULSE_GAP      = 3'd6,
    CFG_PROG_RECOVERY  = 3'd7
  } cfg_idx_e;

  // Phases in which the sequencer can rest between words. Steps that take no
  // time are merged into the phase before them.
  typedef enum logic [4:0] {
    PH_IDLE_DOWN,
    PH_IDLE_OPEN,
    PH_PU_STANDBY,
    PH_PU_TRIM,
    PH_RE_INIT,
    PH_RE_SELECT,
    PH_RD_ADDR,
    PH_RD_CLKHI,
    PH_RD_CLKLO,
    PH_PD_START,
    PH_PD_TRIM,
    PH_PD_STANDBY,
    PH_PE_INIT,
    PH_PE_SELECT,
    PH_PE_PROG,
    PH_PE_TRIM,
    PH_PG_WE_ON,
    PH_PG_WE_OFF,
    PH_PG_NEXT,
    PH_PX_PROG,
    PH_PX_DESEL,
    PH_PX_MODE
  } phase_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] macro_addr;
    logic [BIT_W-1:0]     bit_select;
    logic                 pass_select;
    logic [1:0]           test_mode;
    logic [STB_W-1:0]     strobes;
    logic [WORD_BITS-1:0] read_data;
    logic                 read_valid;
    logic                 busy_res;
  } res_t;

  function automatic logic [CFG_W-1:0] cfg_mask(cfg_idx_e idx);
    logic [CFG_W-1:0] m;
    unique case (idx)
      CFG_PROG_SETUP, CFG_PROG_PULSE: m = 7'h1F;
      CFG_PULSE_GAP:                  m = 7'h07;
      default:                        m = 7'h7F;
    endcase
    return m;
  endfunction

  function automatic logic [CFG_W-1:0] cfg_reset(cfg_idx_e idx);
    logic [CFG_W-1:0] v;
    unique case (idx)
      CFG_ACCESS_SETUP:   v = 7'd50;
      CFG_TRIM_SETUP:     v = 7'd50;
      CFG_SELECT_SETUP:   v = 7'd10;
      CFG_PROG_SEL_SETUP: v = 7'd11;
      CFG_PROG_SETUP:     v = 7'd6;
      CFG_PROG_PULSE:     v = 7'd11;
      CFG_PULSE_GAP:      v = 7'd2;
      default:            v = 7'd6;
    endcase
    return v;
  endfunction

endpackage

### design/otp_macro_access_sequencer.sv
// Top level of the OTP macro access sequencer: ports, sequencer core and output buffer.
// Depends on otp_mas_pkg, otp_mas_ctrl, otp_mas_obuf and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block drives the pins of an OTP memory macro. Each input word is either a
// one-microsecond tick (func 0) or a request to read (func 1) or program (func 2)
// one word. A request while the block is busy, a request of the other kind than
// the open session, and func 3 are ignored. A request in a powered-down state
// runs power-up and the read or program entry, then the access; the session stays
// open until a word marked last, after which exit and power-down follow. All waits
// are counted in ticks, so the caller sets real time by how often it sends ticks;
// the caller must write the eight timing registers through the cfg port only while
// the block is idle, which the block itself does not enforce; a register written as
// zero acts as one. Every accepted input word yields exactly one result word
// carrying the pin values after that word, the last read word, a read strobe that
// is high only on the tick where the macro clock falls and macro_dout_i is sampled,
// and the busy flag. One word per cycle is sustained while the output buffer has
// room; results go into a two-entry output buffer, and the input stalls only when
// both entries are waiting to be taken. No clearing pass follows reset.
module otp_macro_access_sequencer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [otp_mas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [otp_mas_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          func_i,
  input  logic [otp_mas_pkg::ADDR_BITS-1:0]   word_address_i,
  input  logic [otp_mas_pkg::WORD_BITS-1:0]   program_data_i,
  input  logic                                last_word_i,
  input  logic [otp_mas_pkg::WORD_BITS-1:0]   macro_dout_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [otp_mas_pkg::ADDR_BITS-1:0]   macro_addr_o,
  output logic [otp_mas_pkg::BIT_W-1:0]       bit_select_o,
  output logic                                pass_select_o,
  output logic [1:0]                          test_mode_o,
  output logic [otp_mas_pkg::STB_W-1:0]       strobes_o,
  output logic [otp_mas_pkg::WORD_BITS-1:0]   read_data_o,
  output logic                                read_valid_o,
  output logic                                busy_res_o
);

  logic              accept;
  logic              pop;
  logic              push;
  logic              full;
  otp_mas_pkg::res_t res;
  otp_mas_pkg::res_t head;

  // A word is taken whenever the output buffer has room for its result.
  assign accept = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;

  otp_mas_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .func_i         (func_i),
    .word_address_i (word_address_i),
    .program_data_i (program_data_i),
    .last_word_i    (last_word_i),
    .macro_dout_i   (macro_dout_i),
    .push_o         (push),
    .res_o          (res)
  );

  otp_mas_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .full_o      (full),
    .head_o      (head)
  );

  assign in_stall_o    = full;
  assign macro_addr_o  = head.macro_addr;
  assign bit_select_o  = head.bit_select;
  assign pass_select_o = head.pass_select;
  assign test_mode_o   = head.test_mode;
  assign strobes_o     = head.strobes;
  assign read_data_o   = head.read_data;
  assign read_valid_o  = head.read_valid;
  assign busy_res_o    = head.busy_res;

  // The input is held off only while results are waiting.
  `ASSERT_ALWAYS(a_stall_has_results, !in_stall_o || out_valid_o, "stall with empty buffer")
  // A sampled word always comes with the macro clock already low.
  `ASSERT_ALWAYS(a_sample_clock_low, !(push && res.read_valid) || !res.strobes[otp_mas_pkg::STB_CLK], "read sampled with clock high")
  // Write enable is never left high once the sequence has gone idle.
  `ASSERT_ALWAYS(a_idle_we_low, !(push && !res.busy_res) || !res.strobes[otp_mas_pkg::STB_WE], "write enable high while idle")
  // An accepted word with room to spare always leaves a result to take.
  `ASSERT_NEXT(a_accept_gives_result, accept, out_valid_o, "accepted word left no result")

endmodule

### design/otp_mas_ctrl.sv
// Sequencer core of the OTP macro access sequencer: timing registers, phase machine and pins.
// Depends on otp_mas_pkg; produces one result word for every accepted input word.
`timescale 1ns / 1ps
module otp_mas_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [otp_mas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [otp_mas_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                                accept_i,
  input  logic [1:0]                          func_i,
  input  logic [otp_mas_pkg::ADDR_BITS-1:0]   word_address_i,
  input  logic [otp_mas_pkg::WORD_BITS-1:0]   program_data_i,
  input  logic                                last_word_i,
  input  logic [otp_mas_pkg::WORD_BITS-1:0]   macro_dout_i,
  output logic                                push_o,
  output otp_mas_pkg::res_t                   res_o
);

  logic [otp_mas_pkg::CFG_W-1:0] cfg_q [otp_mas_pkg::CFG_NUM];

  otp_mas_pkg::phase_e phase_q, phase_d;
  logic [otp_mas_pkg::WAIT_W-1:0]    wait_q, wait_d;
  logic                              open_q, open_d;
  logic                              is_prog_q, is_prog_d;
  logic                              close_q, close_d;
  logic [otp_mas_pkg::ADDR_BITS-1:0] held_addr_q, held_addr_d;
  logic [otp_mas_pkg::WORD_BITS-1:0] held_word_q, held_word_d;
  logic [otp_mas_pkg::BIT_W-1:0]     bit_q, bit_d;
  logic                              pass_q, pass_d;
  logic [otp_mas_pkg::STB_W-1:0]     stb_q, stb_d;
  logic [1:0]                        mode_q, mode_d;
  logic [otp_mas_pkg::WORD_BITS-1:0] last_read_q, last_read_d;
  logic [otp_mas_pkg::ADDR_BITS-1:0] addr_pin_q, addr_pin_d;
  logic [otp_mas_pkg::BIT_W-1:0]     aio_pin_q, aio_pin_d;
  logic                              pas_pin_q, pas_pin_d;
  logic                              sampled;
  logic                              busy;
  logic                              prog_req;
  logic [otp_mas_pkg::BIT_W-1:0]     bit_inc;

  // A timing register written as zero behaves as one.
  function automatic logic [otp_mas_pkg::WAIT_W-1:0] cw(logic [otp_mas_pkg::CFG_W-1:0] v);
    return (v == '0) ? 7'd1 : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < otp_mas_pkg::CFG_NUM; i++) begin
        cfg_q[i] <= otp_mas_pkg::cfg_reset(
                      otp_mas_pkg::cfg_idx_e'(i[otp_mas_pkg::CFG_IDX_W-1:0]));
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i & otp_mas_pkg::cfg_mask(otp_mas_pkg::cfg_idx_e'(cfg_idx_i));
    end
  end

  assign busy     = (phase_q != otp_mas_pkg::PH_IDLE_DOWN) &&
                    (phase_q != otp_mas_pkg::PH_IDLE_OPEN);
  assign prog_req = (func_i == otp_mas_pkg::FUNC_PROG);
  assign bit_inc  = bit_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    open_d      = open_q;
    is_prog_d   = is_prog_q;
    close_d     = close_q;
    held_addr_d = held_addr_q;
    held_word_d = held_word_q;
    bit_d       = bit_q;
    pass_d      = pass_q;
    stb_d       = stb_q;
    mode_d      = mode_q;
    last_read_d = last_read_q;
    addr_pin_d  = addr_pin_q;
    aio_pin_d   = aio_pin_q;
    pas_pin_d   = pas_pin_q;
    sampled     = 1'b0;

    if (accept_i) begin
      unique case (func_i)
        otp_mas_pkg::FUNC_TICK: begin
          if (busy && wait_q > 7'd1) begin
            wait_d = wait_q - 7'd1;
          end else if (busy) begin
            unique case (phase_q)
              otp_mas_pkg::PH_PU_STANDBY: begin
                stb_d[otp_mas_pkg::STB_STBY] = 1'b1;
                phase_d = otp_mas_pkg::PH_PU_TRIM;
                wait_d  = 7'd2;
              end
              otp_mas_pkg::PH_PU_TRIM: begin
                stb_d[otp_mas_pkg::STB_TRM] = 1'b1;
                phase_d = is_prog_q ? otp_mas_pkg::PH_PE_INIT : otp_mas_pkg::PH_RE_INIT;
                wait_d  = cw(cfg_q[otp_mas_pkg::CFG_TRIM_SETUP]);
              end
              otp_mas_pkg::PH_RE_INIT: begin
                stb_d[otp_mas_pkg::STB_CLK] = 1'b0;
                stb_d[otp_mas_pkg::STB_DIN] = 1'b0;
                stb_d[otp_mas_pkg::STB_WE]  = 1'b0;
                addr_pin_d = '0;
                mode_d     = otp_mas_pkg::MODE_READ;
                phase_d    = otp_mas_pkg::PH_RE_SELECT;
                wait_d     = 7'd1;
              end
              otp_mas_pkg::PH_RE_SELECT: begin
                stb_d[otp_mas_pkg::STB_SEL] = 1'b1;
                phase_d = otp_mas_pkg::PH_RD_ADDR;
                wait_d  = cw(cfg_q[otp_mas_pkg::CFG_SELECT_SETUP]);
              end
              otp_mas_pkg::PH_RD_ADDR: begin
                addr_pin_d = held_addr_q;
                phase_d    = otp_mas_pkg::PH_RD_CLKHI;
                wait_d     = cw(cfg_q[otp_mas_pkg::CFG_ACCESS_SETUP]);
              end
              otp_mas_pkg::PH_RD_CLKHI: begin
                stb_d[otp_mas_pkg::STB_CLK] = 1'b1;
                phase_d = otp_mas_pkg::PH_RD_CLKLO;
                wait_d  = 7'd1;
              end
              otp_mas_pkg::PH_RD_CLKLO: begin
                // The word is taken as the clock falls; a last word runs
                // straight on into the read exit.
                stb_d[otp_mas_pkg::STB_CLK] = 1'b0;
                last_read_d = macro_dout_i;
                sampled     = 1'b1;
                if (close_q) begin
                  stb_d[otp_mas_pkg::STB_DIN] = 1'b0;
                  stb_d[otp_mas_pkg::STB_WE]  = 1'b0;
                  stb_d[otp_mas_pkg::STB_SEL] = 1'b0;
                  addr_pin_d = '0;
                  phase_d    = otp_mas_pkg::PH_PD_START;
                  wait_d     = 7'd1;
                end else begin
                  phase_d = otp_mas_pkg::PH_IDLE_OPEN;
                  wait_d  = '0;
                end
              end
              otp_mas_pkg::PH_PD_START: begin
                phase_d = otp_mas_pkg::PH_PD_TRIM;
                wait_d  = 7'd1;
              end
              otp_mas_pkg::PH_PD_TRIM: begin
                stb_d[otp_mas_pkg::STB_TRM] = 1'b0;
                phase_d = otp_mas_pkg::PH_PD_STANDBY;
                wait_d  = 7'd1;
              end
              otp_mas_pkg::PH_PD_STANDBY: begin
                stb_d[otp_mas_pkg::STB_STBY] = 1'b0;
                open_d  = 1'b0;
                close_d = 1'b0;
                phase_d = otp_mas_pkg::PH_IDLE_DOWN;
                wait_d  = '0;
              end
              otp_mas_pkg::PH_PE_INIT: begin
                stb_d[otp_mas_pkg::STB_CLK] = 1'b0;
                stb_d[otp_mas_pkg::STB_DIN] = 1'b0;
                stb_d[otp_mas_pkg::STB_WE]  = 1'b0;
                addr_pin_d = '0;
                pas_pin_d  = 1'b0;
                aio_pin_d  = '0;
                mode_d     = otp_mas_pkg::MODE_PROG;
                phase_d    = otp_mas_pkg::PH_PE_SELECT;
                wait_d     = 7'd1;
              end
              otp_mas_pkg::PH_PE_SELECT: begin
                stb_d[otp_mas_pkg::STB_SEL] = 1'b1;
                phase_d = otp_mas_pkg::PH_PE_PROG;
                wait_d  = cw(cfg_q[otp_mas_pkg::CFG_PROG_SEL_SETUP]);
              end
              otp_mas_pkg::PH_PE_PROG: begin
                stb_d[otp_mas_pkg::STB_PRG] = 1'b1;
                phase_d = otp_mas_pkg::PH_PE_TRIM;
                wait_d  = cw(cfg_q[otp_mas_pkg::CFG_PROG_SETUP]);
              end
              otp_mas_pkg::PH_PE_TRIM: begin
                // Trim, then the word address and the first bit at once.
                stb_d[otp_mas_pkg::STB_TRM] = 1'b1;
                addr_pin_d = held_addr_q;
                pass_d     = 1'b0;
                bit_d      = '0;
                pas_pin_d  = 1'b0;
                aio_pin_d  = '0;
                stb_d[otp_mas_pkg::STB_DIN] = held_word_q[0];
                phase_d    = otp_mas_pkg::PH_PG_WE_ON;
                wait_d     = 7'd1;
              end
              otp_mas_pkg::PH_PG_WE_ON: begin
                stb_d[otp_mas_pkg::STB_WE] = 1'b1;
                phase_d = otp_mas_pkg::PH_PG_WE_OFF;
                wait_d  = cw(cfg_q[otp_mas_pkg::CFG_PROG_PULSE]);
              end
              otp_mas_pkg::PH_PG_WE_OFF: begin
                stb_d[otp_mas_pkg::STB_WE] = 1'b0;
                phase_d = otp_mas_pkg::PH_PG_NEXT;
                wait_d  = cw(cfg_q[otp_mas_pkg::CFG_PULSE_GAP]);
              end
              otp_mas_pkg::PH_PG_NEXT: begin
                if (bit_q != otp_mas_pkg::BIT_W'(otp_mas_pkg::WORD_BITS - 1)) begin
                  bit_d     = bit_inc;
                  aio_pin_d = bit_inc;
                  pas_pin_d = pass_q;
                  stb_d[otp_mas_pkg::STB_DIN] = held_word_q[bit_inc];
                  phase_d   = otp_mas_pkg::PH_PG_WE_ON;
                  wait_d    = 7'd1;
                end else if (!pass_q) begin
                  bit_d     = '0;
                  pass_d    = 1'b1;
                  aio_pin_d = '0;
                  pas_pin_d = 1'b1;
                  stb_d[otp_mas_pkg::STB_DIN] = held_word_q[0];
                  phase_d   = otp_mas_pkg::PH_PG_WE_ON;
                  wait_d    = 7'd1;
                end else begin
                  bit_d     = '0;
                  pass_d    = 1'b0;
                  pas_pin_d = 1'b0;
                  if (close_q) begin
                    stb_d[otp_mas_pkg::STB_WE] = 1'b0;
                    phase_d = otp_mas_pkg::PH_PX_PROG;
                    wait_d  = 7'd2;
                  end else begin
                    phase_d = otp_mas_pkg::PH_IDLE_OPEN;
                    wait_d  = '0;
                  end
                end
              end
              otp_mas_pkg::PH_PX_PROG: begin
                stb_d[otp_mas_pkg::STB_PRG] = 1'b0;
                phase_d = otp_mas_pkg::PH_PX_DESEL;
                wait_d  = cw(cfg_q[otp_mas_pkg::CFG_PROG_RECOVERY]);
              end
              otp_mas_pkg::PH_PX_DESEL: begin
                stb_d[otp_mas_pkg::STB_SEL] = 1'b0;
                phase_d = otp_mas_pkg::PH_PX_MODE;
                wait_d  = 7'd1;
              end
              otp_mas_pkg::PH_PX_MODE: begin
                mode_d  = otp_mas_pkg::MODE_READ;
                phase_d = otp_mas_pkg::PH_PD_TRIM;
                wait_d  = 7'd1;
              end
              default: begin
                phase_d = otp_mas_pkg::PH_IDLE_DOWN;
                wait_d  = '0;
              end
            endcase
          end
        end
        otp_mas_pkg::FUNC_READ, otp_mas_pkg::FUNC_PROG: begin
          if (!busy && (!open_q || (is_prog_q == prog_req))) begin
            held_addr_d = word_address_i;
            held_word_d = program_data_i;
            close_d     = last_word_i;
            if (!open_q) begin
              open_d    = 1'b1;
              is_prog_d = prog_req;
              phase_d   = otp_mas_pkg::PH_PU_STANDBY;
              wait_d    = 7'd1;
            end else if (prog_req) begin
              addr_pin_d = word_address_i;
              pass_d     = 1'b0;
              bit_d      = '0;
              pas_pin_d  = 1'b0;
              aio_pin_d  = '0;
              stb_d[otp_mas_pkg::STB_DIN] = program_data_i[0];
              phase_d    = otp_mas_pkg::PH_PG_WE_ON;
              wait_d     = 7'd1;
            end else begin
              addr_pin_d = word_address_i;
              phase_d    = otp_mas_pkg::PH_RD_CLKHI;
              wait_d     = cw(cfg_q[otp_mas_pkg::CFG_ACCESS_SETUP]);
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= otp_mas_pkg::PH_IDLE_DOWN;
      wait_q      <= '0;
      open_q      <= 1'b0;
      is_prog_q   <= 1'b0;
      close_q     <= 1'b0;
      held_addr_q <= '0;
      held_word_q <= '0;
      bit_q       <= '0;
      pass_q      <= 1'b0;
      stb_q       <= '0;
      mode_q      <= otp_mas_pkg::MODE_READ;
      last_read_q <= '0;
      addr_pin_q  <= '0;
      aio_pin_q   <= '0;
      pas_pin_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      open_q      <= open_d;
      is_prog_q   <= is_prog_d;
      close_q     <= close_d;
      held_addr_q <= held_addr_d;
      held_word_q <= held_word_d;
      bit_q       <= bit_d;
      pass_q      <= pass_d;
      stb_q       <= stb_d;
      mode_q      <= mode_d;
      last_read_q <= last_read_d;
      addr_pin_q  <= addr_pin_d;
      aio_pin_q   <= aio_pin_d;
      pas_pin_q   <= pas_pin_d;
    end
  end

  assign push_o            = accept_i;
  assign res_o.macro_addr  = addr_pin_d;
  assign res_o.bit_select  = aio_pin_d;
  assign res_o.pass_select = pas_pin_d;
  assign res_o.test_mode   = mode_d;
  assign res_o.strobes     = stb_d;
  assign res_o.read_data   = last_read_d;
  assign res_o.read_valid  = sampled;
  assign res_o.busy_res    = (phase_d != otp_mas_pkg::PH_IDLE_DOWN) &&
                             (phase_d != otp_mas_pkg::PH_IDLE_OPEN);

endmodule

### design/otp_mas_obuf.sv
// Two-entry output buffer of the OTP macro access sequencer, holding result words.
// Depends on otp_mas_pkg for the result word type.
`timescale 1ns / 1ps
module otp_mas_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  otp_mas_pkg::res_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output otp_mas_pkg::res_t head_o
);

  logic [1:0]        count_q, count_d;
  otp_mas_pkg::res_t slot0_q, slot0_d;
  otp_mas_pkg::res_t slot1_q, slot1_d;

  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop_i) begin
      slot0_d = slot1_q;
    end
    if (push_i && pop_i) begin
      if (count_q == 2'd1) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
    end else if (push_i) begin
      count_d = count_q + 2'd1;
      if (count_q == 2'd0) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
    end else if (pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = slot0_q;

endmodule

### verif/otp_mas_pin_checker.sv
// Pin checker for the OTP macro access sequencer: follows the timing registers and input words,
// predicts the macro pins after each word and compares them with the result words of the block.
// Depends on otp_mas_pkg for the function codes, register indexes, strobe positions and widths.
`timescale 1ns / 1ps
module otp_mas_pin_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [otp_mas_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [otp_mas_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        func_i,
  input  logic [otp_mas_pkg::ADDR_BITS-1:0] word_address_i,
  input  logic [otp_mas_pkg::WORD_BITS-1:0] program_data_i,
  input  logic                              last_word_i,
  input  logic [otp_mas_pkg::WORD_BITS-1:0] macro_dout_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [otp_mas_pkg::ADDR_BITS-1:0] macro_addr_i,
  input  logic [otp_mas_pkg::BIT_W-1:0]     bit_select_i,
  input  logic                              pass_select_i,
  input  logic [1:0]                        test_mode_i,
  input  logic [otp_mas_pkg::STB_W-1:0]     strobes_i,
  input  logic [otp_mas_pkg::WORD_BITS-1:0] read_data_i,
  input  logic                              read_valid_i,
  input  logic                              busy_res_i,
  output int unsigned                       mismatch_count_o,
  output int unsigned                       pending_o,
  output logic                              seq_busy_o,
  output logic                              session_open_o,
  output logic                              session_prog_o
);
  import otp_mas_pkg::*;

  // Steps of the waveforms, zero-time steps included.
  typedef enum logic [4:0] {
    S_DOWN, S_OPEN, S_PU_STBY, S_PU_TRIM,
    S_RE_INIT, S_RE_SEL, S_RD_ADDR, S_RD_CLKHI, S_RD_CLKLO, S_RX_EXIT,
    S_PD_START, S_PD_TRIM, S_PD_STBY,
    S_PE_INIT, S_PE_SEL, S_PE_PRG, S_PE_TRIM,
    S_PG_ADDR, S_PG_BIT, S_PG_WE_ON, S_PG_WE_OFF, S_PG_NEXT,
    S_PX_START, S_PX_PRG, S_PX_DESEL, S_PX_MODE
  } seq_step_e;

  logic [CFG_W-1:0]     timing [CFG_NUM];
  seq_step_e            step;
  logic [WAIT_W-1:0]    wait_left;
  logic                 sess_open, sess_prog, close_pend;
  logic [ADDR_BITS-1:0] held_addr, addr_pin;
  logic [WORD_BITS-1:0] held_word, last_read;
  logic [BIT_W-1:0]     bit_cnt, bit_pin;
  logic                 pass_cnt, pass_pin;
  logic [STB_W-1:0]     strobe_pins;
  logic [1:0]           mode_pins;
  logic                 sampled;
  res_t                 expected_pins [$];
  int unsigned          mismatches;

  function automatic logic [CFG_W-1:0] timing_mask(input logic [CFG_IDX_W-1:0] idx);
    case (idx)
      CFG_PROG_SETUP, CFG_PROG_PULSE: return 7'h1F;
      CFG_PULSE_GAP:                  return 7'h07;
      default:                        return 7'h7F;
    endcase
  endfunction

  // A register that holds zero waits one tick.
  function automatic logic [WAIT_W-1:0] wait_of(input cfg_idx_e idx);
    return (timing[idx] == '0) ? 7'd1 : timing[idx];
  endfunction

  function automatic logic at_rest();
    return step == S_DOWN || step == S_OPEN;
  endfunction

  task automatic reset_model();
    timing[CFG_ACCESS_SETUP]   = 7'd50;
    timing[CFG_TRIM_SETUP]     = 7'd50;
    timing[CFG_SELECT_SETUP]   = 7'd10;
    timing[CFG_PROG_SEL_SETUP] = 7'd11;
    timing[CFG_PROG_SETUP]     = 7'd6;
    timing[CFG_PROG_PULSE]     = 7'd11;
    timing[CFG_PULSE_GAP]      = 7'd2;
    timing[CFG_PROG_RECOVERY]  = 7'd6;
    step = S_DOWN;
    wait_left = '0;
    sess_open = 1'b0;
    sess_prog = 1'b0;
    close_pend = 1'b0;
    held_addr = '0;
    held_word = '0;
    last_read = '0;
    bit_cnt = '0;
    pass_cnt = 1'b0;
    strobe_pins = '0;
    mode_pins = MODE_READ;
    addr_pin = '0;
    bit_pin = '0;
    pass_pin = 1'b0;
    sampled = 1'b0;
  endtask

  // Carries out the pin change of the current step, moves on and gives the wait that follows.
  task automatic take_step(input logic [WORD_BITS-1:0] dout, output logic [WAIT_W-1:0] w);
    w = '0;
    case (step)
      S_PU_STBY: begin
        strobe_pins[STB_STBY] = 1'b1;
        step = S_PU_TRIM;
        w = 7'd2;
      end
      S_PU_TRIM: begin
        strobe_pins[STB_TRM] = 1'b1;
        step = sess_prog ? S_PE_INIT : S_RE_INIT;
        w = wait_of(CFG_TRIM_SETUP);
      end
      S_RE_INIT: begin
        strobe_pins[STB_CLK] = 1'b0;
        strobe_pins[STB_DIN] = 1'b0;
        strobe_pins[STB_WE] = 1'b0;
        addr_pin = '0;
        mode_pins = MODE_READ;
        step = S_RE_SEL;
        w = 7'd1;
      end
      S_RE_SEL: begin
        strobe_pins[STB_SEL] = 1'b1;
        step = S_RD_ADDR;
        w = wait_of(CFG_SELECT_SETUP);
      end
      S_RD_ADDR: begin
        addr_pin = held_addr;
        step = S_RD_CLKHI;
        w = wait_of(CFG_ACCESS_SETUP);
      end
      S_RD_CLKHI: begin
        strobe_pins[STB_CLK] = 1'b1;
        step = S_RD_CLKLO;
        w = 7'd1;
      end
      S_RD_CLKLO: begin
        // The macro output is taken as the clock falls.
        strobe_pins[STB_CLK] = 1'b0;
        last_read = dout;
        sampled = 1'b1;
        step = close_pend ? S_RX_EXIT : S_OPEN;
      end
      S_RX_EXIT: begin
        strobe_pins[STB_CLK] = 1'b0;
        strobe_pins[STB_DIN] = 1'b0;
        strobe_pins[STB_WE] = 1'b0;
        strobe_pins[STB_SEL] = 1'b0;
        addr_pin = '0;
        step = S_PD_START;
        w = 7'd1;
      end
      S_PD_START: begin
        step = S_PD_TRIM;
        w = 7'd1;
      end
      S_PD_TRIM: begin
        strobe_pins[STB_TRM] = 1'b0;
        step = S_PD_STBY;
        w = 7'd1;
      end
      S_PD_STBY: begin
        strobe_pins[STB_STBY] = 1'b0;
        sess_open = 1'b0;
        close_pend = 1'b0;
        step = S_DOWN;
      end
      S_PE_INIT: begin
        strobe_pins[STB_CLK] = 1'b0;
        strobe_pins[STB_DIN] = 1'b0;
        strobe_pins[STB_WE] = 1'b0;
        addr_pin = '0;
        pass_pin = 1'b0;
        bit_pin = '0;
        mode_pins = MODE_PROG;
        step = S_PE_SEL;
        w = 7'd1;
      end
      S_PE_SEL: begin
        strobe_pins[STB_SEL] = 1'b1;
        step = S_PE_PRG;
        w = wait_of(CFG_PROG_SEL_SETUP);
      end
      S_PE_PRG: begin
        strobe_pins[STB_PRG] = 1'b1;
        step = S_PE_TRIM;
        w = wait_of(CFG_PROG_SETUP);
      end
      S_PE_TRIM: begin
        strobe_pins[STB_TRM] = 1'b1;
        step = S_PG_ADDR;
      end
      S_PG_ADDR: begin
        addr_pin = held_addr;
        pass_cnt = 1'b0;
        bit_cnt = '0;
        step = S_PG_BIT;
      end
      S_PG_BIT: begin
        pass_pin = pass_cnt;
        bit_pin = bit_cnt;
        strobe_pins[STB_DIN] = held_word[bit_cnt];
        step = S_PG_WE_ON;
        w = 7'd1;
      end
      S_PG_WE_ON: begin
        strobe_pins[STB_WE] = 1'b1;
        step = S_PG_WE_OFF;
        w = wait_of(CFG_PROG_PULSE);
      end
      S_PG_WE_OFF: begin
        strobe_pins[STB_WE] = 1'b0;
        step = S_PG_NEXT;
        w = wait_of(CFG_PULSE_GAP);
      end
      S_PG_NEXT: begin
        if (int'(bit_cnt) + 1 < WORD_BITS) begin
          bit_cnt = bit_cnt + 1'b1;
          step = S_PG_BIT;
        end else begin
          bit_cnt = '0;
          if (!pass_cnt) begin
            pass_cnt = 1'b1;
            step = S_PG_BIT;
          end else begin
            pass_cnt = 1'b0;
            pass_pin = 1'b0;
            step = close_pend ? S_PX_START : S_OPEN;
          end
        end
      end
      S_PX_START: begin
        strobe_pins[STB_WE] = 1'b0;
        step = S_PX_PRG;
        w = 7'd2;
      end
      S_PX_PRG: begin
        strobe_pins[STB_PRG] = 1'b0;
        step = S_PX_DESEL;
        w = wait_of(CFG_PROG_RECOVERY);
      end
      S_PX_DESEL: begin
        strobe_pins[STB_SEL] = 1'b0;
        step = S_PX_MODE;
        w = 7'd1;
      end
      S_PX_MODE: begin
        mode_pins = MODE_READ;
        step = S_PD_START;
      end
      default: begin
        if (step != S_OPEN) step = S_DOWN;
      end
    endcase
  endtask

  // Runs zero-time steps until a wait begins or the sequencer comes to rest.
  task automatic run_to_wait(input logic [WORD_BITS-1:0] dout);
    logic [WAIT_W-1:0] w;
    int                guard;
    logic              held;
    wait_left = '0;
    held = 1'b0;
    for (guard = 0; guard < 256 && !held; guard++) begin
      if (at_rest()) begin
        held = 1'b1;
      end else begin
        take_step(dout, w);
        if (at_rest()) begin
          held = 1'b1;
        end else if (w != '0) begin
          wait_left = w;
          held = 1'b1;
        end
      end
    end
  endtask

  task automatic apply_word(input logic [1:0] fn, input logic [ADDR_BITS-1:0] adr,
                            input logic [WORD_BITS-1:0] dat, input logic lst,
                            input logic [WORD_BITS-1:0] dout);
    logic busy_now;
    logic want_prog;
    busy_now = !at_rest();
    sampled = 1'b0;
    if (fn == FUNC_TICK) begin
      if (busy_now) begin
        if (wait_left > 7'd1) wait_left = wait_left - 1'b1;
        else run_to_wait(dout);
      end
    end else if ((fn == FUNC_READ || fn == FUNC_PROG) && !busy_now) begin
      want_prog = (fn == FUNC_PROG);
      // A request of the other kind than the open session is dropped.
      if (!sess_open || sess_prog == want_prog) begin
        held_addr = adr;
        held_word = dat;
        close_pend = lst;
        if (!sess_open) begin
          sess_open = 1'b1;
          sess_prog = want_prog;
          step = S_PU_STBY;
          wait_left = 7'd1;
        end else begin
          step = want_prog ? S_PG_ADDR : S_RD_ADDR;
          run_to_wait(dout);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50)
      $display("%0t: %s got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t pins;
    if (!rst_ni) begin
      reset_model();
      expected_pins.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
      seq_busy_o <= 1'b0;
      session_open_o <= 1'b0;
      session_prog_o <= 1'b0;
    end else begin
      if (cfg_we_i) timing[cfg_idx_i] = cfg_data_i & timing_mask(cfg_idx_i);
      if (in_valid_i && !in_stall_i) begin
        apply_word(func_i, word_address_i, program_data_i, last_word_i, macro_dout_i);
        pins.macro_addr  = addr_pin;
        pins.bit_select  = bit_pin;
        pins.pass_select = pass_pin;
        pins.test_mode   = mode_pins;
        pins.strobes     = strobe_pins;
        pins.read_data   = last_read;
        pins.read_valid  = sampled;
        pins.busy_res    = !at_rest();
        expected_pins.push_back(pins);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pins.size() == 0) begin
          report_mismatch("result word with nothing expected", '0, '0);
        end else begin
          pins = expected_pins.pop_front();
          check_field("macro_addr", 32'(macro_addr_i), 32'(pins.macro_addr));
          check_field("bit_select", 32'(bit_select_i), 32'(pins.bit_select));
          check_field("pass_select", 32'(pass_select_i), 32'(pins.pass_select));
          check_field("test_mode", 32'(test_mode_i), 32'(pins.test_mode));
          check_field("strobes", 32'(strobes_i), 32'(pins.strobes));
          check_field("read_data", read_data_i, pins.read_data);
          check_field("read_valid", 32'(read_valid_i), 32'(pins.read_valid));
          check_field("busy_res", 32'(busy_res_i), 32'(pins.busy_res));
        end
      end
      mismatch_count_o <= mismatches;
      pending_o <= expected_pins.size();
      seq_busy_o <= !at_rest();
      session_open_o <= sess_open;
      session_prog_o <= sess_prog;
    end
  end

endmodule

### verif/otp_macro_access_sequencer_tb.sv
// Testbench top of the OTP macro access sequencer: clock, reset, timing register writes and
// input words, with a random receiver; otp_mas_pin_checker predicts and compares beside the block.
// Depends on otp_mas_pkg, otp_macro_access_sequencer and otp_mas_pin_checker.
`timescale 1ns / 1ps
module otp_macro_access_sequencer_tb;
  import otp_mas_pkg::*;

  // Function code that the block does not use; it must leave everything unchanged.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // A correct run ends far short of this limit.
  localparam int unsigned CYCLE_LIMIT = 100000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           func_i;
  logic [ADDR_BITS-1:0] word_address_i;
  logic [WORD_BITS-1:0] program_data_i;
  logic                 last_word_i;
  logic [WORD_BITS-1:0] macro_dout_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ADDR_BITS-1:0] macro_addr_o;
  logic [BIT_W-1:0]     bit_select_o;
  logic                 pass_select_o;
  logic [1:0]           test_mode_o;
  logic [STB_W-1:0]     strobes_o;
  logic [WORD_BITS-1:0] read_data_o;
  logic                 read_valid_o;
  logic                 busy_res_o;

  int unsigned mismatch_count;
  int unsigned words_pending;
  logic        seq_busy;
  logic        session_open;
  logic        session_prog;

  // When calm is set neither the sender nor the receiver idles.
  logic        calm = 1'b0;
  int unsigned cycle_count = 0;

  otp_macro_access_sequencer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .word_address_i (word_address_i),
    .program_data_i (program_data_i),
    .last_word_i    (last_word_i),
    .macro_dout_i   (macro_dout_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .macro_addr_o   (macro_addr_o),
    .bit_select_o   (bit_select_o),
    .pass_select_o  (pass_select_o),
    .test_mode_o    (test_mode_o),
    .strobes_o      (strobes_o),
    .read_data_o    (read_data_o),
    .read_valid_o   (read_valid_o),
    .busy_res_o     (busy_res_o)
  );

  otp_mas_pin_checker i_pin_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .func_i           (func_i),
    .word_address_i   (word_address_i),
    .program_data_i   (program_data_i),
    .last_word_i      (last_word_i),
    .macro_dout_i     (macro_dout_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .macro_addr_i     (macro_addr_o),
    .bit_select_i     (bit_select_o),
    .pass_select_i    (pass_select_o),
    .test_mode_i      (test_mode_o),
    .strobes_i        (strobes_o),
    .read_data_i      (read_data_o),
    .read_valid_i     (read_valid_o),
    .busy_res_i       (busy_res_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (words_pending),
    .seq_busy_o       (seq_busy),
    .session_open_o   (session_open),
    .session_prog_o   (session_prog)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The receiver stalls in roughly a quarter of the cycles, except during calm stretches.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 24);
  end

  // Watchdog: a run that has not ended by the limit has hung or lost result words.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one word and returns at the clock edge at which it is taken. Random idle cycles
  // come first, so gaps fall at every point of the waveforms. The payload is held while the
  // block stalls, and valid is never lowered and raised in the same time step.
  task automatic send_word(input logic [1:0] fn, input logic [ADDR_BITS-1:0] adr,
                           input logic [WORD_BITS-1:0] dat, input logic lst,
                           input logic [WORD_BITS-1:0] dout);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    word_address_i <= adr;
    program_data_i <= dat;
    last_word_i    <= lst;
    macro_dout_i   <= dout;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // A tick carries junk in the request fields; only the macro output matters to it.
  task automatic send_tick(input logic [WORD_BITS-1:0] dout);
    send_word(FUNC_TICK, 12'($urandom_range(0, 4095)), $urandom,
              1'($urandom_range(0, 1)), dout);
  endtask

  // The busy flag from the checker is one word behind at the edge where a word is taken,
  // so the loop runs until two words in a row have found the sequencer at rest.
  task automatic run_out(input logic [WORD_BITS-1:0] dout);
    do send_tick(dout); while (seq_busy);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  // Brings the block to rest: finishes any sequence, closes an open session with a last word
  // of its own kind and lets every result word out.
  task automatic settle_block();
    run_out($urandom);
    if (session_open) begin
      send_word(session_prog ? FUNC_PROG : FUNC_READ, 12'($urandom_range(0, 4095)),
                $urandom, 1'b1, $urandom);
      run_out($urandom);
    end
    drain_results();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Writes every timing register with a value drawn from low..high; the block keeps only
  // the bits of each register's width.
  task automatic load_timing(input int unsigned low, input int unsigned high);
    for (int i = 0; i < CFG_NUM; i++) write_reg(cfg_idx_e'(i), 7'($urandom_range(high, low)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic counted in words that the block acts on. Most words follow well-formed
  // sessions: ticks while a sequence runs, requests of the open kind when it rests. The rest
  // are requests while busy, requests of the wrong kind, the unused code and idle ticks.
  task automatic random_traffic(input int unsigned target);
    int unsigned done_items;
    int unsigned pick;
    logic        want_prog;
    done_items = 0;
    while (done_items < target) begin
      pick = $urandom_range(0, 99);
      if (seq_busy) begin
        if (pick < 94) begin
          send_tick($urandom);
          done_items++;
        end else begin
          send_word(2'($urandom_range(1, 2)), 12'($urandom_range(0, 4095)), $urandom,
                    1'($urandom_range(0, 1)), $urandom);
        end
      end else if (pick < 70) begin
        want_prog = session_open ? session_prog : 1'($urandom_range(0, 1));
        send_word(want_prog ? FUNC_PROG : FUNC_READ, 12'($urandom_range(0, 4095)), $urandom,
                  $urandom_range(0, 99) < 35, $urandom);
        done_items++;
      end else if (pick < 80) begin
        want_prog = session_open ? !session_prog : 1'($urandom_range(0, 1));
        send_word(want_prog ? FUNC_PROG : FUNC_READ, 12'($urandom_range(0, 4095)), $urandom,
                  1'($urandom_range(0, 1)), $urandom);
      end else if (pick < 90) begin
        send_word(FUNC_UNUSED, 12'($urandom_range(0, 4095)), $urandom,
                  1'($urandom_range(0, 1)), $urandom);
      end else begin
        send_tick($urandom);
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_ACCESS_SETUP;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    func_i         <= FUNC_TICK;
    word_address_i <= '0;
    program_data_i <= '0;
    last_word_i    <= 1'b0;
    macro_dout_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset timing values. A tick and the unused code while powered
    // down must change nothing.
    send_tick('1);
    send_word(FUNC_UNUSED, '1, '1, 1'b1, '1);
    // A read opens a session at the top address; requests that arrive while it powers up
    // are ignored, whichever kind they are. The word sampled here is all ones.
    send_word(FUNC_READ, '1, '0, 1'b0, '1);
    send_word(FUNC_READ, '0, '1, 1'b1, '0);
    send_word(FUNC_PROG, 12'h555, '1, 1'b1, '0);
    run_out('1);
    // With the read session open, a program request and the unused code are ignored; the
    // last read at address zero samples all zeros and powers the macro down.
    send_word(FUNC_PROG, '0, '1, 1'b1, '0);
    send_word(FUNC_UNUSED, '0, '0, 1'b0, '0);
    send_word(FUNC_READ, '0, '1, 1'b1, '0);
    run_out('0);
    settle_block();

    // One-tick pulses and gaps keep a program word short; the values written carry high
    // bits that the narrow registers must drop. The other waits stay at their reset values.
    write_reg(CFG_PROG_PULSE, 7'h61);
    write_reg(CFG_PULSE_GAP, 7'h79);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    // A program session: all ones at address zero, then a read request of the wrong kind,
    // then a mixed word that closes the session.
    send_word(FUNC_PROG, '0, '1, 1'b0, '0);
    run_out($urandom);
    send_word(FUNC_READ, '1, '0, 1'b1, '1);
    send_word(FUNC_PROG, 12'hA5A, 32'h5A5A_A5A5, 1'b1, '0);
    run_out($urandom);
    // A single-word read session after a program session: the pins left by programming
    // must be cleared or kept exactly as the waveform says.
    send_word(FUNC_READ, 12'($urandom_range(0, 4095)), $urandom, 1'b1, $urandom);
    run_out($urandom);
    settle_block();

    // Every register written as zero must wait a single tick.
    load_timing(0, 0);
    random_traffic(120);
    settle_block();

    // Short waits keep program words quick. The sender pauses once until every result word
    // has come, and a calm stretch follows.
    load_timing(0, 3);
    random_traffic(60);
    drain_results();
    calm = 1'b1;
    random_traffic(100);
    calm = 1'b0;
    random_traffic(60);
    settle_block();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && words_pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
